### hdl/pmwd_pkg.sv
// Shared constants, types and configuration codes of the PIR motion window detector.
`timescale 1ns / 1ps

package pmwd_pkg;

    localparam int MAX_WINDOW_DEF  = 128;
    localparam int SAMPLE_BITS_DEF = 14;

    localparam int Y_W       = 24;
    localparam int ACC_W     = 48;
    localparam int FB_W      = 22;
    localparam int GAIN_W    = 21;
    localparam int COEF_FRAC = 20;
    localparam int IN_SHIFT  = 8;

    localparam int LIMIT_W   = 16;
    localparam int MINX_W    = 8;
    localparam int WLEN_W    = 8;
    localparam int HOLD_W    = 12;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(896);
    localparam logic [MINX_W-1:0]  MINX_RST  = MINX_W'(3);
    localparam logic [WLEN_W-1:0]  WLEN_RST  = WLEN_W'(100);
    localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(292);

    localparam logic signed [GAIN_W-1:0] INV_GAIN_Q20 = 21'sd352278;

    localparam logic signed [FB_W-1:0] FB_COEF [6] = '{
        22'sd1754613, -22'sd140310, -22'sd383847,
        -22'sd530427, 22'sd231766, 22'sd114238
    };

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(524288);
    localparam logic signed [ACC_W-1:0] ACC_Y_MAX  = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] ACC_Y_MIN  = ACC_W'(-8388608);
    localparam logic signed [Y_W-1:0]   Y_MAX      = 24'sh7FFFFF;
    localparam logic signed [Y_W-1:0]   Y_MIN      = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT      = 8'd0,
        CFG_MIN_CROSS  = 8'd1,
        CFG_WINDOW_LEN = 8'd2,
        CFG_HOLDOFF    = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [MINX_W-1:0]  min_cross;
        logic [WLEN_W-1:0]  win_len;
        logic [HOLD_W-1:0]  holdoff;
        logic               restart;
    } t_cfg;

endpackage

### hdl/pmwd_iir.sv
// Two-stage fixed-point bandpass filter with input history and transposed feedback state.
`timescale 1ns / 1ps

module pmwd_iir #(
    parameter int SAMPLE_BITS = pmwd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [SAMPLE_BITS-1:0]             i_raw_sample,
    output logic                               o_y_valid,
    input  logic                               i_y_ready,
    output logic signed [pmwd_pkg::Y_W-1:0]    o_y
);

    localparam int XS_W = SAMPLE_BITS + 4;
    localparam int XP_W = XS_W + pmwd_pkg::GAIN_W;

    logic [SAMPLE_BITS-1:0]               r_hist [6];
    logic                                 r_v1;
    logic signed [pmwd_pkg::ACC_W-1:0]    r_xprod;
    logic                                 r_v2;
    logic signed [pmwd_pkg::Y_W-1:0]      r_y;
    logic signed [pmwd_pkg::ACC_W-1:0]    r_z [5];

    logic signed [XS_W-1:0]               w_x0, w_x2, w_x4, w_x6;
    logic signed [XS_W-1:0]               w_da, w_db, w_xsum;
    logic signed [XP_W-1:0]               w_xprod;
    logic signed [pmwd_pkg::ACC_W-1:0]    n_xprod;
    logic signed [pmwd_pkg::ACC_W-1:0]    w_prod [6];
    logic signed [pmwd_pkg::ACC_W-1:0]    w_acc;
    logic signed [pmwd_pkg::ACC_W-1:0]    w_rnd;
    logic signed [pmwd_pkg::Y_W-1:0]      n_y;
    logic signed [pmwd_pkg::ACC_W-1:0]    n_z [5];
    logic                                 w_accept;
    logic                                 w_en2;
    logic                                 w_s2_free;

    assign w_s2_free  = !r_v2 || i_y_ready;
    assign w_en2      = r_v1 && w_s2_free;
    assign o_in_ready = !r_v1 || w_en2;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_y_valid  = r_v2;
    assign o_y        = r_y;

    always_comb begin
        w_x0   = $signed(XS_W'(i_raw_sample));
        w_x2   = $signed(XS_W'(r_hist[1]));
        w_x4   = $signed(XS_W'(r_hist[3]));
        w_x6   = $signed(XS_W'(r_hist[5]));
        w_da   = w_x0 - w_x6;
        w_db   = w_x4 - w_x2;
        w_xsum = w_da + w_db + (w_db <<< 1);
    end

    assign w_xprod = w_xsum * pmwd_pkg::INV_GAIN_Q20;
    assign n_xprod = pmwd_pkg::ACC_W'(w_xprod) <<< pmwd_pkg::IN_SHIFT;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_prod[k] = pmwd_pkg::FB_COEF[k] * r_y;
        end
        for (int m = 0; m < 4; m++) begin
            n_z[m] = w_prod[m+1] + r_z[m+1];
        end
        n_z[4] = w_prod[5];
        w_acc = r_xprod + w_prod[0] + r_z[0];
        w_rnd = (w_acc + pmwd_pkg::ROUND_HALF) >>> pmwd_pkg::COEF_FRAC;
        if (w_rnd > pmwd_pkg::ACC_Y_MAX) begin
            n_y = pmwd_pkg::Y_MAX;
        end else if (w_rnd < pmwd_pkg::ACC_Y_MIN) begin
            n_y = pmwd_pkg::Y_MIN;
        end else begin
            n_y = w_rnd[pmwd_pkg::Y_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_y  <= '0;
            for (int k = 0; k < 6; k++) begin
                r_hist[k] <= '0;
            end
            for (int m = 0; m < 5; m++) begin
                r_z[m] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_en2) begin
                r_v1 <= 1'b0;
            end
            r_v2 <= w_en2 || (r_v2 && !i_y_ready);
            if (w_accept) begin
                r_hist[0] <= i_raw_sample;
                for (int k = 1; k < 6; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
            end
            if (w_en2) begin
                r_y <= n_y;
                for (int m = 0; m < 5; m++) begin
                    r_z[m] <= n_z[m];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_xprod <= n_xprod;
        end
    end

endmodule

### hdl/pmwd_window.sv
// Threshold classification, class ring memory, running counts, holdoff and output register.
`timescale 1ns / 1ps

module pmwd_window #(
    parameter int MAX_WINDOW = pmwd_pkg::MAX_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pmwd_pkg::t_cfg                     i_cfg,
    input  logic                               i_y_valid,
    output logic                               o_y_ready,
    input  logic signed [pmwd_pkg::Y_W-1:0]    i_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pmwd_pkg::Y_W-1:0]    o_filtered_q8,
    output logic                               o_presence,
    output logic                               o_decided
);

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_POS,
        CLS_NEG
    } t_cls;

    t_cls                              r_mem [MAX_WINDOW];
    t_cls                              r_rdata;
    logic                              r_v3;
    logic signed [pmwd_pkg::Y_W-1:0]   r_y3;
    t_cls                              r_cls3;
    logic                              r_ov;
    logic signed [pmwd_pkg::Y_W-1:0]   r_filt;
    logic                              r_pres;
    logic                              r_dec;
    logic [IDX_W-1:0]                  r_widx;
    logic [LEN_W-1:0]                  r_fill;
    logic [LEN_W-1:0]                  r_pos;
    logic [LEN_W-1:0]                  r_neg;
    logic [pmwd_pkg::HOLD_W-1:0]       r_hold;

    logic [IDX_W-1:0]                  n_widx;
    logic [LEN_W-1:0]                  n_fill;
    logic [LEN_W-1:0]                  n_pos;
    logic [LEN_W-1:0]                  n_neg;
    logic [pmwd_pkg::HOLD_W-1:0]       n_hold;
    logic [LEN_W-1:0]                  w_len;
    logic signed [pmwd_pkg::Y_W-1:0]   w_lim;
    t_cls                              w_cls;
    logic                              w_wr_en;
    logic                              w_pres;
    logic                              w_dec;
    logic                              w_out_free;
    logic                              w_en_out;
    logic                              w_en3;

    assign w_out_free  = !r_ov || i_out_ready;
    assign w_en_out    = r_v3 && w_out_free;
    assign o_y_ready   = !r_v3 || w_en_out;
    assign w_en3       = i_y_valid && o_y_ready;
    assign o_out_valid = r_ov;
    assign o_filtered_q8 = r_filt;
    assign o_presence  = r_pres;
    assign o_decided   = r_dec;

    always_comb begin
        if (i_cfg.win_len == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(i_cfg.win_len) > MAX_WINDOW) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(i_cfg.win_len);
        end
    end

    always_comb begin
        w_lim = $signed(pmwd_pkg::Y_W'(i_cfg.limit));
        if (i_y > w_lim) begin
            w_cls = CLS_POS;
        end else if (i_y < -w_lim) begin
            w_cls = CLS_NEG;
        end else begin
            w_cls = CLS_NONE;
        end
    end

    always_comb begin
        n_widx  = r_widx;
        n_fill  = r_fill;
        n_pos   = r_pos;
        n_neg   = r_neg;
        n_hold  = r_hold;
        w_wr_en = 1'b0;
        w_pres  = 1'b0;
        w_dec   = 1'b0;
        if (w_en_out) begin
            if (r_hold != '0) begin
                n_hold = r_hold - 1'b1;
            end else begin
                w_wr_en = 1'b1;
                if (r_fill >= w_len) begin
                    if (r_rdata == CLS_POS && r_pos != '0) begin
                        n_pos = r_pos - 1'b1;
                    end
                    if (r_rdata == CLS_NEG && r_neg != '0) begin
                        n_neg = r_neg - 1'b1;
                    end
                end else begin
                    n_fill = r_fill + 1'b1;
                end
                if (r_cls3 == CLS_POS) begin
                    n_pos = n_pos + 1'b1;
                end
                if (r_cls3 == CLS_NEG) begin
                    n_neg = n_neg + 1'b1;
                end
                if (LEN_W'(r_widx) + LEN_W'(1) == w_len) begin
                    n_widx = '0;
                end else begin
                    n_widx = r_widx + 1'b1;
                end
                if (n_fill >= w_len) begin
                    w_dec = 1'b1;
                    if (int'(n_pos) >= int'(i_cfg.min_cross) &&
                        int'(n_neg) >= int'(i_cfg.min_cross)) begin
                        w_pres = 1'b1;
                        n_hold = i_cfg.holdoff;
                        n_widx = '0;
                        n_fill = '0;
                        n_pos  = '0;
                        n_neg  = '0;
                    end
                end
            end
        end
        if (i_cfg.restart) begin
            n_widx = '0;
            n_fill = '0;
            n_pos  = '0;
            n_neg  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_widx] <= r_cls3;
        end
        if (w_en3) begin
            if (w_wr_en && r_widx == n_widx) begin
                r_rdata <= r_cls3;
            end else begin
                r_rdata <= r_mem[n_widx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3   <= 1'b0;
            r_ov   <= 1'b0;
            r_widx <= '0;
            r_fill <= '0;
            r_pos  <= '0;
            r_neg  <= '0;
            r_hold <= '0;
        end else begin
            r_v3   <= w_en3 || (r_v3 && !w_en_out);
            r_ov   <= w_en_out || (r_ov && !i_out_ready);
            r_widx <= n_widx;
            r_fill <= n_fill;
            r_pos  <= n_pos;
            r_neg  <= n_neg;
            r_hold <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_y3   <= i_y;
            r_cls3 <= w_cls;
        end
        if (w_en_out) begin
            r_filt <= r_y3;
            r_pres <= w_pres;
            r_dec  <= w_dec;
        end
    end

endmodule

### hdl/pir_motion_window_detector.sv
// Top level of the PIR motion window detector: configuration registers and the two datapath parts.
`timescale 1ns / 1ps

// Each accepted raw sample produces exactly one output beat carrying the bandpass value, the
// presence flag and the decided flag. The block sustains one sample per clock cycle when the
// output is not stalled; a beat passes the filter product register, the filter output register
// and the classification register on its way to the output register. The rate is set by the
// filter feedback path, a combinational constant multiply-add with rounding and saturation, and
// by the class ring, a memory with one read and one write port that is read as each sample
// enters the classification register and written as it leaves, with forwarding for a
// one-entry window. No clearing pass is needed after reset. Configuration writes are taken in
// any cycle, and a write to the window length restarts the window.
module pir_motion_window_detector #(
    parameter int MAX_WINDOW  = pmwd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = pmwd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0]                 i_raw_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pmwd_pkg::Y_W-1:0]        o_filtered_q8,
    output logic                                   o_presence,
    output logic                                   o_decided,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pmwd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pmwd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [pmwd_pkg::LIMIT_W-1:0]      r_limit;
    logic [pmwd_pkg::MINX_W-1:0]       r_min_cross;
    logic [pmwd_pkg::WLEN_W-1:0]       r_win_len;
    logic [pmwd_pkg::HOLD_W-1:0]       r_holdoff;
    logic                              w_cfg_wr;
    pmwd_pkg::t_cfg                    w_cfg;
    logic                              w_y_valid;
    logic                              w_y_ready;
    logic signed [pmwd_pkg::Y_W-1:0]   w_y;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        w_cfg.limit     = r_limit;
        w_cfg.min_cross = r_min_cross;
        w_cfg.win_len   = r_win_len;
        w_cfg.holdoff   = r_holdoff;
        w_cfg.restart   = w_cfg_wr &&
                          (i_cfg_index == pmwd_pkg::CFG_IDX_W'(pmwd_pkg::CFG_WINDOW_LEN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= pmwd_pkg::LIMIT_RST;
            r_min_cross <= pmwd_pkg::MINX_RST;
            r_win_len   <= pmwd_pkg::WLEN_RST;
            r_holdoff   <= pmwd_pkg::HOLD_RST;
        end else if (w_cfg_wr) begin
            unique case (pmwd_pkg::t_cfg_idx'(i_cfg_index))
                pmwd_pkg::CFG_LIMIT: begin
                    r_limit <= i_cfg_data[pmwd_pkg::LIMIT_W-1:0];
                end
                pmwd_pkg::CFG_MIN_CROSS: begin
                    r_min_cross <= i_cfg_data[pmwd_pkg::MINX_W-1:0];
                end
                pmwd_pkg::CFG_WINDOW_LEN: begin
                    r_win_len <= i_cfg_data[pmwd_pkg::WLEN_W-1:0];
                end
                pmwd_pkg::CFG_HOLDOFF: begin
                    r_holdoff <= i_cfg_data[pmwd_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pmwd_iir #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_iir (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_raw_sample (i_raw_sample),
        .o_y_valid    (w_y_valid),
        .i_y_ready    (w_y_ready),
        .o_y          (w_y)
    );

    pmwd_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_y_valid     (w_y_valid),
        .o_y_ready     (w_y_ready),
        .i_y           (w_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_filtered_q8 (o_filtered_q8),
        .o_presence    (o_presence),
        .o_decided     (o_decided)
    );

endmodule
